// ----- rtl/polygon_kernel_test_assert.svh -----
// assertion macros used by the polygon kernel clipping engine
`ifndef POLYGON_KERNEL_TEST_ASSERT_SVH
`define POLYGON_KERNEL_TEST_ASSERT_SVH

// same-cycle implication, clocked on clk and quiet while in reset
`define PK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pk_pkg.sv -----
// shared types and constants of the polygon kernel block
package pk_pkg;

	localparam int MAX_VERTICES_DEF = 128;
	localparam int WORK_DEPTH_DEF   = 256;

	localparam int COORD_W   = 16;
	localparam int PT_W      = 32;
	localparam int FRAC_W    = 16;
	localparam int SIDE_W    = 52;
	localparam int MAG_W     = 52;
	localparam int DEN_W     = 31;
	localparam int NUM_W     = 64;
	localparam int JOB_CNT_W = 11;
	localparam int CNT_OUT_W = 9;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} vertex_t;

	typedef struct packed {
		logic                 bank;
		logic [JOB_CNT_W-1:0] count;
		logic                 dropped;
	} job_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

endpackage

// ----- rtl/pk_ram.sv -----
// generic simple dual-port ram with registered read
module pk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/pk_front.sv -----
// input side: stores vertices into a free bank and queues a job per polygon
module pk_front #(
	parameter int MAX_VERTICES = 128
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [pk_pkg::COORD_W-1:0]      vertex_x,
	input  logic signed [pk_pkg::COORD_W-1:0]      vertex_y,
	input  logic                                   last_vertex,
	input  logic                                   vertex_valid,
	output logic                                   vertex_stall,
	output logic                                   pwe,
	output logic [$clog2(MAX_VERTICES):0]          pwaddr,
	output pk_pkg::vertex_t                        pwdata,
	output logic                                   push,
	output pk_pkg::job_t                           push_job,
	input  logic                                   q_full,
	input  pk_pkg::release_t                       rel
);
	import pk_pkg::*;

	localparam int PI_W = $clog2(MAX_VERTICES);
	localparam int PC_W = $clog2(MAX_VERTICES + 1);

	logic [PC_W-1:0] cnt_q, cnt_nx;
	logic            dropped_q, drop_nx;
	logic            wbank_q;
	logic [1:0]      busy_q, busy_nx;
	logic            accept, room;

	assign vertex_stall = busy_q[wbank_q] | q_full;
	assign accept       = vertex_valid & ~vertex_stall;
	assign room         = (cnt_q != PC_W'(MAX_VERTICES));

	assign pwe    = accept & room;
	assign pwaddr = {wbank_q, cnt_q[PI_W-1:0]};
	assign pwdata = '{x: vertex_x, y: vertex_y};

	assign cnt_nx  = room ? cnt_q + 1'b1 : cnt_q;
	assign drop_nx = dropped_q | ~room;

	assign push     = accept & last_vertex;
	assign push_job = '{bank: wbank_q, count: JOB_CNT_W'(cnt_nx), dropped: drop_nx};

	always_comb begin
		busy_nx = busy_q;
		if (rel.valid) begin
			busy_nx[rel.bank] = 1'b0;
		end
		if (push) begin
			busy_nx[wbank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			wbank_q   <= 1'b0;
			busy_q    <= '0;
		end else begin
			busy_q <= busy_nx;
			if (accept) begin
				if (last_vertex) begin
					cnt_q     <= '0;
					dropped_q <= 1'b0;
					wbank_q   <= ~wbank_q;
				end else begin
					cnt_q     <= cnt_nx;
					dropped_q <= drop_nx;
				end
			end
		end
	end

endmodule

// ----- rtl/pk_queue.sv -----
// two-entry job queue between the input side and the clipping engine
module pk_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  pk_pkg::job_t push_job,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output pk_pkg::job_t head
);
	import pk_pkg::*;

	job_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] fill_q;
	logic       do_push, do_pop;

	assign full    = (fill_q == 2'd2);
	assign empty   = (fill_q == 2'd0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- rtl/pk_div.sv -----
// bit-serial signed divider, quotient truncated toward zero
module pk_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [pk_pkg::NUM_W-1:0]   num,
	input  logic        [pk_pkg::DEN_W-1:0]   den,
	output logic                              busy,
	output logic                              done,
	output logic signed [pk_pkg::PT_W-1:0]    quo
);
	import pk_pkg::*;

	localparam int MQ_W  = NUM_W - 1;
	localparam int CNT_W = $clog2(MQ_W + 1);

	logic             busy_q, done_q, neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [MQ_W-1:0]  nq_q;
	logic [NUM_W-1:0] num_mag;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign rem_sh  = {rem_q, nq_q[MQ_W-1]};
	assign ge      = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			nq_q  <= num_mag[MQ_W-1:0];
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
			nq_q  <= {nq_q[MQ_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MQ_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = neg_q ? -$signed(nq_q[PT_W-1:0]) : $signed(nq_q[PT_W-1:0]);

endmodule

// ----- rtl/pk_back.sv -----
// clipping engine: cuts the working polygon by each edge line and reports
`include "polygon_kernel_test_assert.svh"

module pk_back #(
	parameter int MAX_VERTICES = 128,
	parameter int WORK_DEPTH   = 256
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    q_empty,
	input  pk_pkg::job_t                            head,
	output logic                                    pop,
	output pk_pkg::release_t                        rel,
	output logic [$clog2(MAX_VERTICES):0]           praddr,
	input  pk_pkg::vertex_t                         prdata,
	output logic                                    wwe,
	output logic [$clog2(WORK_DEPTH):0]             waddr,
	output logic [2*pk_pkg::PT_W-1:0]               wdata,
	output logic [$clog2(WORK_DEPTH):0]             wraddr,
	input  logic [2*pk_pkg::PT_W-1:0]               wrdata,
	output logic                                    kernel_exists,
	output logic [pk_pkg::CNT_OUT_W-1:0]            kernel_vertex_count,
	output logic                                    store_overflow,
	output logic                                    result_valid,
	input  logic                                    result_stall
);
	import pk_pkg::*;

	localparam int PI_W = $clog2(MAX_VERTICES);
	localparam int PC_W = $clog2(MAX_VERTICES + 1);
	localparam int WI_W = $clog2(WORK_DEPTH);
	localparam int WC_W = $clog2(WORK_DEPTH + 1);

	typedef struct packed {
		logic signed [PT_W-1:0] x;
		logic signed [PT_W-1:0] y;
	} point_t;

	typedef enum logic [26:0] {
		B_IDLE     = 27'h0000001,
		B_LOAD_RD  = 27'h0000002,
		B_LOAD_WR  = 27'h0000004,
		B_LINE_R1  = 27'h0000008,
		B_LINE_R2  = 27'h0000010,
		B_LINE_M1  = 27'h0000020,
		B_LINE_M2  = 27'h0000040,
		B_LINE_M3  = 27'h0000080,
		B_PT_RD    = 27'h0000100,
		B_SIDE_A   = 27'h0000200,
		B_SIDE_B   = 27'h0000400,
		B_SIDE_C   = 27'h0000800,
		B_DECIDE   = 27'h0001000,
		B_CX_ABS   = 27'h0002000,
		B_CX_NORM  = 27'h0004000,
		B_CX_MX1   = 27'h0008000,
		B_CX_MX2   = 27'h0010000,
		B_CX_MX3   = 27'h0020000,
		B_CX_DIVX  = 27'h0040000,
		B_CX_MY1   = 27'h0080000,
		B_CX_MY2   = 27'h0100000,
		B_CX_MY3   = 27'h0200000,
		B_CX_DIVY  = 27'h0400000,
		B_EMIT     = 27'h0800000,
		B_ADVANCE  = 27'h1000000,
		B_PASS_END = 27'h2000000,
		B_DONE     = 27'h4000000
	} bstate_t;

	typedef enum logic [1:0] {
		PH_PRV,
		PH_CUR,
		PH_NXT
	} phase_t;

	bstate_t state_q, state_nx;
	phase_t  ph_q;

	// job
	logic            bank_q, drop_q, fail_q;
	logic [PC_W-1:0] n_q, e_q, e1;

	// working polygon bookkeeping
	logic            src_q;
	logic [WC_W-1:0] m_q, t_q, i_q;
	logic [WI_W-1:0] rd_idx_q, nidx_q;

	// edge line
	logic signed [COORD_W-1:0] vx1_q, vy1_q, vx2_q, vy2_q;
	logic signed [COORD_W:0]   a_q, b_q;
	logic signed [PT_W-1:0]    c_q;
	logic signed [NUM_W-1:0]   ctmp_q;

	// shared multiplier
	logic signed [PT_W-1:0]  mul_a, mul_b;
	logic signed [NUM_W-1:0] mul_q;

	// side evaluation
	point_t                  pt_new_q, prv_pt_q, cur_pt_q, nxt_pt_q, emit_pt_q;
	point_t                  rd_pt, pa, pb;
	logic signed [SIDE_W-1:0] acc_q, f_new, prv_f_q, cur_f_q, nxt_f_q, fa, fb;
	logic                    prv_pos, nxt_pos;

	// intersection
	logic                    cx_sel_q, pend2_q;
	logic [MAG_W-1:0]        u_q, v_q;
	logic [MAG_W:0]          uv_sum;
	logic [DEN_W-1:0]        d_q;
	logic signed [NUM_W-1:0] num_q;
	logic signed [PT_W-1:0]  qx_q;

	logic                    div_start, div_busy, div_done;
	logic signed [NUM_W-1:0] div_num;
	logic signed [PT_W-1:0]  div_quo;

	logic slot_free, res_load, room;

	function automatic logic [WI_W-1:0] step_idx(input logic [WI_W-1:0] idx,
		input logic [WC_W-1:0] cnt);
		logic [WC_W-1:0] nx;
		nx = WC_W'(idx) + 1'b1;
		return (nx == cnt) ? '0 : WI_W'(nx);
	endfunction

	assign rd_pt   = wrdata;
	assign e1      = (e_q + 1'b1 == n_q) ? '0 : e_q + 1'b1;
	assign prv_pos = ~prv_f_q[SIDE_W-1] & (prv_f_q != '0);
	assign nxt_pos = ~nxt_f_q[SIDE_W-1] & (nxt_f_q != '0);
	assign pa      = cx_sel_q ? cur_pt_q : prv_pt_q;
	assign pb      = cx_sel_q ? nxt_pt_q : cur_pt_q;
	assign fa      = cx_sel_q ? cur_f_q : prv_f_q;
	assign fb      = cx_sel_q ? nxt_f_q : cur_f_q;
	assign f_new   = acc_q + SIDE_W'(mul_q);
	assign uv_sum  = {1'b0, u_q} + {1'b0, v_q};
	assign room    = (t_q != WC_W'(WORK_DEPTH));

	assign slot_free = ~result_valid | ~result_stall;
	assign res_load  = (state_q == B_DONE) & slot_free;
	assign pop       = (state_q == B_IDLE) & ~q_empty;
	assign rel       = '{valid: res_load, bank: bank_q};

	assign praddr = (state_q == B_LINE_R2) ? {bank_q, e1[PI_W-1:0]}
	                                       : {bank_q, e_q[PI_W-1:0]};
	assign wraddr = {src_q, rd_idx_q};

	always_comb begin
		wwe   = 1'b0;
		waddr = {~src_q, WI_W'(t_q)};
		wdata = emit_pt_q;
		if (state_q == B_LOAD_WR) begin
			wwe   = 1'b1;
			waddr = {src_q, WI_W'(e_q)};
			wdata = {prdata.x, FRAC_W'(0), prdata.y, FRAC_W'(0)};
		end else if (state_q == B_EMIT) begin
			wwe = room;
		end
	end

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			B_LINE_M1: begin
				mul_a = PT_W'(prdata.x);
				mul_b = PT_W'(vy1_q);
			end
			B_LINE_M2: begin
				mul_a = PT_W'(vy2_q);
				mul_b = PT_W'(vx1_q);
			end
			B_SIDE_A: begin
				mul_a = PT_W'(a_q);
				mul_b = rd_pt.x;
			end
			B_SIDE_B: begin
				mul_a = PT_W'(b_q);
				mul_b = pt_new_q.y;
			end
			B_CX_MX1: begin
				mul_a = $signed({1'b0, v_q[DEN_W-1:0]});
				mul_b = pa.x;
			end
			B_CX_MX2: begin
				mul_a = $signed({1'b0, u_q[DEN_W-1:0]});
				mul_b = pb.x;
			end
			B_CX_MY1: begin
				mul_a = $signed({1'b0, v_q[DEN_W-1:0]});
				mul_b = pa.y;
			end
			B_CX_MY2: begin
				mul_a = $signed({1'b0, u_q[DEN_W-1:0]});
				mul_b = pb.y;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	assign div_start = (state_q == B_CX_MX3) | (state_q == B_CX_MY3);
	assign div_num   = num_q + mul_q;

	pk_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (d_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer
	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (32'(head.count) > WORK_DEPTH) begin
						state_nx = B_DONE;
					end else begin
						state_nx = B_LOAD_RD;
					end
				end
			end
			B_LOAD_RD:  state_nx = B_LOAD_WR;
			B_LOAD_WR:  state_nx = (e_q + 1'b1 == n_q) ? B_LINE_R1 : B_LOAD_RD;
			B_LINE_R1:  state_nx = B_LINE_R2;
			B_LINE_R2:  state_nx = B_LINE_M1;
			B_LINE_M1:  state_nx = B_LINE_M2;
			B_LINE_M2:  state_nx = B_LINE_M3;
			B_LINE_M3:  state_nx = (m_q == '0) ? B_PASS_END : B_PT_RD;
			B_PT_RD:    state_nx = B_SIDE_A;
			B_SIDE_A:   state_nx = B_SIDE_B;
			B_SIDE_B:   state_nx = B_SIDE_C;
			B_SIDE_C:   state_nx = (ph_q == PH_NXT) ? B_DECIDE : B_PT_RD;
			B_DECIDE: begin
				if (!cur_f_q[SIDE_W-1]) begin
					state_nx = B_EMIT;
				end else if (prv_pos || nxt_pos) begin
					state_nx = B_CX_ABS;
				end else begin
					state_nx = B_ADVANCE;
				end
			end
			B_CX_ABS:   state_nx = B_CX_NORM;
			B_CX_NORM: begin
				if (uv_sum > (MAG_W + 1)'(32'h7FFF_FFFF)) begin
					state_nx = B_CX_NORM;
				end else if (uv_sum == '0) begin
					state_nx = B_EMIT;
				end else begin
					state_nx = B_CX_MX1;
				end
			end
			B_CX_MX1:   state_nx = B_CX_MX2;
			B_CX_MX2:   state_nx = B_CX_MX3;
			B_CX_MX3:   state_nx = B_CX_DIVX;
			B_CX_DIVX:  state_nx = div_done ? B_CX_MY1 : B_CX_DIVX;
			B_CX_MY1:   state_nx = B_CX_MY2;
			B_CX_MY2:   state_nx = B_CX_MY3;
			B_CX_MY3:   state_nx = B_CX_DIVY;
			B_CX_DIVY:  state_nx = div_done ? B_EMIT : B_CX_DIVY;
			B_EMIT: begin
				if (!room) begin
					state_nx = B_DONE;
				end else if (pend2_q) begin
					state_nx = B_CX_ABS;
				end else begin
					state_nx = B_ADVANCE;
				end
			end
			B_ADVANCE:  state_nx = (i_q + 1'b1 == m_q) ? B_PASS_END : B_PT_RD;
			B_PASS_END: state_nx = (e_q + 1'b1 == n_q) ? B_DONE : B_LINE_R1;
			B_DONE:     state_nx = slot_free ? B_IDLE : B_DONE;
			default:    state_nx = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (res_load) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				n_q    <= PC_W'(head.count);
				bank_q <= head.bank;
				drop_q <= head.dropped;
				fail_q <= (32'(head.count) > WORK_DEPTH);
				src_q  <= 1'b0;
				e_q    <= '0;
			end
			B_LOAD_WR: begin
				if (e_q + 1'b1 == n_q) begin
					m_q <= WC_W'(n_q);
					e_q <= '0;
				end else begin
					e_q <= e_q + 1'b1;
				end
			end
			B_LINE_R2: begin
				vx1_q <= prdata.x;
				vy1_q <= prdata.y;
			end
			B_LINE_M1: begin
				vx2_q <= prdata.x;
				vy2_q <= prdata.y;
			end
			B_LINE_M2: begin
				ctmp_q <= mul_q;
			end
			B_LINE_M3: begin
				c_q      <= PT_W'(ctmp_q - mul_q);
				a_q      <= (COORD_W + 1)'(vy2_q) - (COORD_W + 1)'(vy1_q);
				b_q      <= (COORD_W + 1)'(vx1_q) - (COORD_W + 1)'(vx2_q);
				t_q      <= '0;
				i_q      <= '0;
				rd_idx_q <= WI_W'(m_q - 1'b1);
				nidx_q   <= step_idx('0, m_q);
				ph_q     <= PH_PRV;
			end
			B_SIDE_A: begin
				pt_new_q <= rd_pt;
			end
			B_SIDE_B: begin
				acc_q <= SIDE_W'(mul_q) + (SIDE_W'(c_q) <<< FRAC_W);
			end
			B_SIDE_C: begin
				case (ph_q)
					PH_PRV: begin
						prv_pt_q <= pt_new_q;
						prv_f_q  <= f_new;
						rd_idx_q <= '0;
						ph_q     <= PH_CUR;
					end
					PH_CUR: begin
						cur_pt_q <= pt_new_q;
						cur_f_q  <= f_new;
						rd_idx_q <= nidx_q;
						ph_q     <= PH_NXT;
					end
					default: begin
						nxt_pt_q <= pt_new_q;
						nxt_f_q  <= f_new;
					end
				endcase
			end
			B_DECIDE: begin
				// a kept point goes straight out, an outside one makes crossings toward neighbours on the inside
				emit_pt_q <= cur_pt_q;
				pend2_q   <= 1'b0;
				if (cur_f_q[SIDE_W-1]) begin
					if (prv_pos) begin
						cx_sel_q <= 1'b0;
						pend2_q  <= nxt_pos;
					end else begin
						cx_sel_q <= 1'b1;
					end
				end
			end
			B_CX_ABS: begin
				u_q <= fa[SIDE_W-1] ? MAG_W'(-fa) : MAG_W'(fa);
				v_q <= fb[SIDE_W-1] ? MAG_W'(-fb) : MAG_W'(fb);
			end
			B_CX_NORM: begin
				if (uv_sum > (MAG_W + 1)'(32'h7FFF_FFFF)) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
				end else begin
					d_q       <= DEN_W'(uv_sum);
					emit_pt_q <= pa;
				end
			end
			B_CX_MX2, B_CX_MY2: begin
				num_q <= mul_q;
			end
			B_CX_DIVX: begin
				if (div_done) begin
					qx_q <= div_quo;
				end
			end
			B_CX_DIVY: begin
				if (div_done) begin
					emit_pt_q <= '{x: qx_q, y: div_quo};
				end
			end
			B_EMIT: begin
				if (!room) begin
					fail_q <= 1'b1;
				end else begin
					t_q <= t_q + 1'b1;
					if (pend2_q) begin
						cx_sel_q <= 1'b1;
						pend2_q  <= 1'b0;
					end
				end
			end
			B_ADVANCE: begin
				i_q      <= i_q + 1'b1;
				prv_pt_q <= cur_pt_q;
				prv_f_q  <= cur_f_q;
				cur_pt_q <= nxt_pt_q;
				cur_f_q  <= nxt_f_q;
				rd_idx_q <= step_idx(nidx_q, m_q);
				nidx_q   <= step_idx(nidx_q, m_q);
			end
			B_PASS_END: begin
				src_q <= ~src_q;
				m_q   <= t_q;
				e_q   <= e_q + 1'b1;
			end
			B_DONE: begin
				if (res_load) begin
					kernel_exists       <= ~fail_q & (m_q != '0);
					kernel_vertex_count <= fail_q ? '0 :
						((32'(m_q) > 32'd511) ? CNT_OUT_W'(511) : CNT_OUT_W'(m_q));
					store_overflow      <= fail_q | drop_q;
				end
			end
			default: begin
			end
		endcase
	end

	`PK_ASSERT_NOW(a_emit_room, wwe && (state_q == B_EMIT), t_q < WC_W'(WORK_DEPTH), "emit past store")
	`PK_ASSERT_NOW(a_div_free, div_start, !div_busy, "divider restarted while busy")
	`PK_ASSERT_NEXT(a_release_result, rel.valid, result_valid, "bank released without result")

endmodule

// ----- rtl/polygon_kernel_test.sv -----
// top level of the polygon kernel test block
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------------
//  vertex   | vertex_valid / vertex_stall | vertex_x, vertex_y, last_vertex
//  result   | result_valid / result_stall | kernel_exists, kernel_vertex_count,
//           |                             | store_overflow
//
// the input side keeps taking vertices of the next polygon into the second bank while
// the clipping engine works on the previous one
// a polygon is first copied vertex by vertex into the working store; then, for each
// of its edges, the engine reads the edge line, evaluates the side of every working
// point, writes kept points out and works out each crossing one coordinate at a time
// on the single serial divider, after halving large weights; one shared multiplier
// serves every product
// reset clears control state only; the stores need no clearing pass
// the input stalls only when both polygon banks are owned by queued or running jobs,
// and a waiting result holds the engine in its final state until it is taken
module polygon_kernel_test #(
	parameter int MAX_VERTICES = pk_pkg::MAX_VERTICES_DEF,
	parameter int WORK_DEPTH   = pk_pkg::WORK_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [pk_pkg::COORD_W-1:0]   vertex_x,
	input  logic signed [pk_pkg::COORD_W-1:0]   vertex_y,
	input  logic                                last_vertex,
	input  logic                                vertex_valid,
	output logic                                vertex_stall,
	output logic                                kernel_exists,
	output logic [pk_pkg::CNT_OUT_W-1:0]        kernel_vertex_count,
	output logic                                store_overflow,
	output logic                                result_valid,
	input  logic                                result_stall
);
	import pk_pkg::*;

	localparam int PA_W = $clog2(MAX_VERTICES) + 1;
	localparam int WA_W = $clog2(WORK_DEPTH) + 1;

	// polygon store, two banks side by side
	logic            pwe;
	logic [PA_W-1:0] pwaddr, praddr;
	vertex_t         pwdata, prdata;

	// working and scratch stores share one ram, swapped per pass
	logic              wwe;
	logic [WA_W-1:0]   waddr, wraddr;
	logic [2*PT_W-1:0] wdata, wrdata;

	// job hand-over
	logic     push, q_full, pop, q_empty;
	job_t     push_job, head;
	release_t rel;

	pk_ram #(
		.WIDTH (2 * COORD_W),
		.DEPTH (2 ** PA_W)
	) u_poly_ram (
		.clk   (clk),
		.we    (pwe),
		.waddr (pwaddr),
		.wdata (pwdata),
		.raddr (praddr),
		.rdata (prdata)
	);

	pk_ram #(
		.WIDTH (2 * PT_W),
		.DEPTH (2 ** WA_W)
	) u_work_ram (
		.clk   (clk),
		.we    (wwe),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (wraddr),
		.rdata (wrdata)
	);

	pk_front #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.last_vertex  (last_vertex),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.pwe          (pwe),
		.pwaddr       (pwaddr),
		.pwdata       (pwdata),
		.push         (push),
		.push_job     (push_job),
		.q_full       (q_full),
		.rel          (rel)
	);

	pk_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	pk_back #(
		.MAX_VERTICES (MAX_VERTICES),
		.WORK_DEPTH   (WORK_DEPTH)
	) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.q_empty             (q_empty),
		.head                (head),
		.pop                 (pop),
		.rel                 (rel),
		.praddr              (praddr),
		.prdata              (prdata),
		.wwe                 (wwe),
		.waddr               (waddr),
		.wdata               (wdata),
		.wraddr              (wraddr),
		.wrdata              (wrdata),
		.kernel_exists       (kernel_exists),
		.kernel_vertex_count (kernel_vertex_count),
		.store_overflow      (store_overflow),
		.result_valid        (result_valid),
		.result_stall        (result_stall)
	);

endmodule
